@@ rtl/core/link_quality_statistics_defines.svh @@
// Assertion macros shared by the link statistics RTL
`ifndef LINK_QUALITY_STATISTICS_DEFINES_SVH
`define LINK_QUALITY_STATISTICS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define LQS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("link statistics check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define LQS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("link statistics check failed");

`endif

@@ rtl/core/lqs_pkg.sv @@
// Types and constants for the link statistics block
`timescale 1ns / 1ps
`default_nettype none

package lqs_pkg;

    localparam int DIV_W = 32;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [15:0] FAILSAFE_RST = 16'd1000;
    localparam logic [15:0] WINDOW_RST   = 16'd1000;
    localparam logic [31:0] LAST_ACK_RST = 32'(0) - 32'(FAILSAFE_RST);

    localparam logic [9:0] RATE_SCALE = 10'd1000;
    localparam logic [6:0] PCT_SCALE  = 7'd100;
    localparam logic [6:0] QUAL_MAX   = 7'd100;

    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'd1;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SEND   = 3'd1,
        OP_ACK    = 3'd2,
        OP_ERROR  = 3'd3,
        OP_MISSED = 3'd4,
        OP_UPDATE = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE_CHK,
        S_RATE_DIV,
        S_QUAL_CHK,
        S_QUAL_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

@@ rtl/core/lqs_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module lqs_div
    import lqs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // shift one dividend bit into the partial remainder per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/link_quality_statistics.sv @@
// Transmit link statistics: event counters, window quality, telemetry rate, failsafe
//
// Input channel (i_in_valid / o_in_stall) carries one request: op, telemetry
// length and missed count. Output channel (o_out_valid / i_out_stall) returns
// exactly one result per request with the statistics after that request.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) writes the failsafe
// period (index 0) or window length (index 1); write only while idle.
// Counting, tick and clear requests go from the idle state straight to the
// emit state, which loads the result. An update request checks both windows
// in a check state each; the rate window when it closes, and the quality
// window when it closes with packets in it, runs the shared bit-serial divider.
// The divider produces one quotient bit per cycle.
// One request is processed at a time; the next is accepted as soon as the
// result moved into the output register, even while that result waits.
// When the receiver stalls, the result is held and a finished second result
// waits inside until the output register frees.
// Reset (synchronous, active low) clears all statistics, sets both registers
// to 1000 ms and marks the last acknowledge 1000 ms in the past, so failsafe
// reads as set.
`timescale 1ns / 1ps
`default_nettype none
`include "link_quality_statistics_defines.svh"

module link_quality_statistics
    import lqs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [2:0]           i_op,
    input  wire logic [7:0]           i_telemetry_length,
    input  wire logic [15:0]          i_missed_count,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_failsafe,
    output logic [6:0]                o_link_quality_pct,
    output logic [7:0]                o_acked_per_window,
    output logic [31:0]               o_telemetry_rate,
    output logic [31:0]               o_sent_count,
    output logic [31:0]               o_acked_count,
    output logic [31:0]               o_error_count,
    output logic [31:0]               o_missed_total,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [15:0] r_failsafe_period;
    logic [15:0] r_window;

    logic [31:0] r_now;
    logic [31:0] r_sent;
    logic [31:0] r_acked;
    logic [31:0] r_errors;
    logic [31:0] r_missed;
    logic [31:0] r_last_ack;
    logic [15:0] r_mark_acked;
    logic [15:0] r_mark_total;
    logic [31:0] r_qual_start;
    logic [6:0]  r_quality_last;
    logic [7:0]  r_acked_win_last;
    logic [31:0] r_tlm_bytes;
    logic [31:0] r_tlm_mark;
    logic [31:0] r_rate_last;
    logic [31:0] r_rate_start;

    logic        r_out_valid;
    logic        r_out_failsafe;
    logic [6:0]  r_out_quality;
    logic [7:0]  r_out_acked_win;
    logic [31:0] r_out_rate;
    logic [31:0] r_out_sent;
    logic [31:0] r_out_acked;
    logic [31:0] r_out_errors;
    logic [31:0] r_out_missed;

    logic        w_accept;
    logic        w_out_free;
    logic        w_load_out;
    logic        w_rate_close;
    logic        w_qual_close;
    logic [31:0] w_rate_elapsed;
    logic [31:0] w_qual_elapsed;
    logic [31:0] w_tlm_delta;
    logic [15:0] w_win_acked;
    logic [15:0] w_win_total;
    logic        w_failsafe;
    logic [6:0]  w_quality_sat;
    t_div_req    w_div_req;
    logic        w_div_done;
    logic [31:0] w_div_quot;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_rate_elapsed = r_now - r_rate_start;
    assign w_qual_elapsed = r_now - r_qual_start;
    assign w_rate_close   = w_rate_elapsed > {16'b0, r_window};
    assign w_qual_close   = w_qual_elapsed > {16'b0, r_window};
    assign w_tlm_delta    = r_tlm_bytes - r_tlm_mark;
    assign w_win_acked    = r_acked[15:0] - r_mark_acked;
    assign w_win_total    = r_sent[15:0] + r_missed[15:0] - r_mark_total;
    assign w_failsafe     = (r_now - r_last_ack) >= {16'b0, r_failsafe_period};
    assign w_quality_sat  = (w_div_quot > 32'(QUAL_MAX)) ? QUAL_MAX : w_div_quot[6:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_op) == OP_UPDATE) ? S_RATE_CHK : S_EMIT;
                end
            end
            S_RATE_CHK: begin
                n_state = w_rate_close ? S_RATE_DIV : S_QUAL_CHK;
            end
            S_RATE_DIV: begin
                if (w_div_done) begin
                    n_state = S_QUAL_CHK;
                end
            end
            S_QUAL_CHK: begin
                n_state = (w_qual_close && (w_win_total != '0)) ? S_QUAL_DIV : S_EMIT;
            end
            S_QUAL_DIV: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall         = 1'b1;
        w_load_out         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = 32'(w_tlm_delta * 32'(RATE_SCALE));
        w_div_req.divisor  = w_rate_elapsed;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_RATE_CHK: begin
                w_div_req.start = w_rate_close;
            end
            S_QUAL_CHK: begin
                w_div_req.start    = w_qual_close && (w_win_total != '0);
                w_div_req.dividend = {9'b0, {7'b0, w_win_acked} * {16'b0, PCT_SCALE}};
                w_div_req.divisor  = {16'b0, w_win_total};
            end
            S_EMIT: begin
                w_load_out = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    lqs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failsafe_period <= FAILSAFE_RST;
            r_window          <= WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FAILSAFE: r_failsafe_period <= i_cfg_data;
                REG_WINDOW:   r_window          <= i_cfg_data;
                default:      r_window          <= r_window;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now            <= '0;
            r_sent           <= '0;
            r_acked          <= '0;
            r_errors         <= '0;
            r_missed         <= '0;
            r_last_ack       <= LAST_ACK_RST;
            r_mark_acked     <= '0;
            r_mark_total     <= '0;
            r_qual_start     <= '0;
            r_quality_last   <= '0;
            r_acked_win_last <= '0;
            r_tlm_bytes      <= '0;
            r_tlm_mark       <= '0;
            r_rate_last      <= '0;
            r_rate_start     <= '0;
        end else begin
            if (w_accept) begin
                case (t_op'(i_op))
                    OP_TICK:   r_now    <= r_now + 1'b1;
                    OP_SEND:   r_sent   <= r_sent + 1'b1;
                    OP_ACK: begin
                        r_acked     <= r_acked + 1'b1;
                        r_tlm_bytes <= r_tlm_bytes + {24'b0, i_telemetry_length};
                        r_last_ack  <= r_now;
                    end
                    OP_ERROR:  r_errors <= r_errors + 1'b1;
                    OP_MISSED: r_missed <= r_missed + {16'b0, i_missed_count};
                    OP_CLEAR: begin
                        r_sent         <= '0;
                        r_acked        <= '0;
                        r_errors       <= '0;
                        r_missed       <= '0;
                        r_last_ack     <= r_now - {16'b0, r_failsafe_period};
                        r_mark_acked   <= '0;
                        r_mark_total   <= '0;
                        r_qual_start   <= r_now;
                        r_quality_last <= '0;
                        r_tlm_bytes    <= '0;
                        r_tlm_mark     <= '0;
                        r_rate_last    <= '0;
                        r_rate_start   <= r_now;
                    end
                    default: r_now <= r_now;
                endcase
            end
            // advance the window marks when a window closes, as its divide starts; the totals hold meanwhile
            if ((r_state == S_RATE_CHK) && w_rate_close) begin
                r_tlm_mark   <= r_tlm_bytes;
                r_rate_start <= r_now;
            end
            if ((r_state == S_RATE_DIV) && w_div_done) begin
                r_rate_last <= w_div_quot;
            end
            if ((r_state == S_QUAL_CHK) && w_qual_close) begin
                r_acked_win_last <= (|w_win_acked[15:8]) ? 8'hFF : w_win_acked[7:0];
                r_mark_acked     <= r_acked[15:0];
                r_mark_total     <= r_sent[15:0] + r_missed[15:0];
                r_qual_start     <= r_now;
                if (w_win_total == '0) begin
                    r_quality_last <= '0;
                end
            end
            if ((r_state == S_QUAL_DIV) && w_div_done) begin
                r_quality_last <= w_quality_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_failsafe  <= w_failsafe;
            r_out_quality   <= r_quality_last;
            r_out_acked_win <= r_acked_win_last;
            r_out_rate      <= r_rate_last;
            r_out_sent      <= r_sent;
            r_out_acked     <= r_acked;
            r_out_errors    <= r_errors;
            r_out_missed    <= r_missed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_failsafe         = r_out_failsafe;
    assign o_link_quality_pct = r_out_quality;
    assign o_acked_per_window = r_out_acked_win;
    assign o_telemetry_rate   = r_out_rate;
    assign o_sent_count       = r_out_sent;
    assign o_acked_count      = r_out_acked;
    assign o_error_count      = r_out_errors;
    assign o_missed_total     = r_out_missed;

    `LQS_ASSERT_IMP(a_quality_range, 1'b1, r_quality_last <= QUAL_MAX)
    `LQS_ASSERT_IMP(a_div_done_state, w_div_done, (r_state == S_RATE_DIV) || (r_state == S_QUAL_DIV))
    `LQS_ASSERT_NXT(a_emit_loads, (r_state == S_EMIT) && w_out_free, o_out_valid && (r_state == S_IDLE))
    `LQS_ASSERT_IMP(a_div_start_idle, w_div_req.start, (r_state == S_RATE_CHK) || (r_state == S_QUAL_CHK))

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for link_quality_statistics: directed table, then random traffic checked against a predictor
`timescale 1ns / 1ps

module testbench
    import lqs_pkg::*;
();

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIRECTED_SPLIT = 10;
    localparam int PHASES         = 6;
    localparam int BURST_PHASE    = 1;
    localparam int HOLD_PHASE     = 4;
    localparam int ACK_BURST      = 260;
    localparam int MAX_REPORTS    = 40;

    localparam logic [31:0] MS_PER_S       = 32'd1000;
    localparam logic [31:0] PCT_FULL       = 32'd100;
    localparam logic [31:0] WINDOW_ACK_MAX = 32'd255;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd1000;

    typedef struct packed {
        logic        failsafe;
        logic [6:0]  quality_pct;
        logic [7:0]  acked_window;
        logic [31:0] rate;
        logic [31:0] sent;
        logic [31:0] acked;
        logic [31:0] errors;
        logic [31:0] missed;
    } t_stats;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  length;
        logic [15:0] missed;
        logic        typed;
        t_stats      want;
    } t_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [2:0]           in_op     = OP_TICK;
    logic [7:0]           in_length = '0;
    logic [15:0]          in_missed = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FAILSAFE;
    logic [15:0]          cfg_data  = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_failsafe;
    logic [6:0]  o_link_quality_pct;
    logic [7:0]  o_acked_per_window;
    logic [31:0] o_telemetry_rate;
    logic [31:0] o_sent_count;
    logic [31:0] o_acked_count;
    logic [31:0] o_error_count;
    logic [31:0] o_missed_total;
    logic        o_cfg_ready;

    // Predicted copy of the block's registers and statistics
    logic [15:0] model_failsafe;
    logic [15:0] model_window;
    logic [31:0] ms_now;
    logic [31:0] n_sent;
    logic [31:0] n_acked;
    logic [31:0] n_errors;
    logic [31:0] n_missed;
    logic [31:0] last_ack_ms;
    logic [31:0] q_mark_acked;
    logic [31:0] q_mark_total;
    logic [31:0] q_start;
    logic [6:0]  q_pct;
    logic [7:0]  w_acked;
    logic [31:0] tl_bytes;
    logic [31:0] tl_mark;
    logic [31:0] tl_rate;
    logic [31:0] r_start;

    t_stats pending_results[$];
    t_row   directed_rows[$];

    int fail_count     = 0;
    int report_count   = 0;
    int n_requests     = 0;
    int n_results      = 0;
    int windows_closed = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    bit hold_pending   = 1'b0;
    bit hold_taken     = 1'b0;

    logic [15:0] phase_failsafe [0:PHASES-1] = '{16'hFFFF, 16'd5, 16'd0, 16'd40, 16'd12, 16'd7};
    logic [15:0] phase_window   [0:PHASES-1] = '{16'd0, 16'd3, 16'd8, 16'hFFFF, 16'd20, 16'd2};
    int          phase_items    [0:PHASES-1] = '{120, 200, 120, 120, 250, 250};
    int          phase_send_idle[0:PHASES-1] = '{16, 16, 74, 74, 0, 0};
    int          phase_recv_idle[0:PHASES-1] = '{74, 74, 16, 16, 0, 0};

    link_quality_statistics uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (in_op),
        .i_telemetry_length (in_length),
        .i_missed_count     (in_missed),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_failsafe         (o_failsafe),
        .o_link_quality_pct (o_link_quality_pct),
        .o_acked_per_window (o_acked_per_window),
        .o_telemetry_rate   (o_telemetry_rate),
        .o_sent_count       (o_sent_count),
        .o_acked_count      (o_acked_count),
        .o_error_count      (o_error_count),
        .o_missed_total     (o_missed_total),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic t_stats stats_of(logic fs, logic [6:0] pct, logic [7:0] aw,
                                        logic [31:0] rate, logic [31:0] sent,
                                        logic [31:0] acked, logic [31:0] errors,
                                        logic [31:0] missed);
        t_stats s;
        s.failsafe     = fs;
        s.quality_pct  = pct;
        s.acked_window = aw;
        s.rate         = rate;
        s.sent         = sent;
        s.acked        = acked;
        s.errors       = errors;
        s.missed       = missed;
        return s;
    endfunction

    function automatic t_row traffic_row(logic [2:0] op, logic [7:0] len, logic [15:0] miss);
        t_row r;
        r        = '0;
        r.op     = op;
        r.length = len;
        r.missed = miss;
        return r;
    endfunction

    task automatic add_row(logic [2:0] op, logic [7:0] len, logic [15:0] miss,
                           logic typed, t_stats want);
        t_row r;
        r       = traffic_row(op, len, miss);
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Restart every statistic at the current millisecond; now and the window ack count stay
    function automatic void restart_link_stats();
        n_sent       = '0;
        n_acked      = '0;
        n_errors     = '0;
        n_missed     = '0;
        last_ack_ms  = ms_now - {16'd0, model_failsafe};
        q_mark_acked = '0;
        q_mark_total = '0;
        q_start      = ms_now;
        q_pct        = '0;
        tl_bytes     = '0;
        tl_mark      = '0;
        tl_rate      = '0;
        r_start      = ms_now;
    endfunction

    function automatic t_stats advance_link_stats(logic [2:0] op, logic [7:0] len,
                                                  logic [15:0] miss);
        logic [31:0] span;
        logic [31:0] scaled;
        logic [31:0] all_pkts;
        logic [31:0] win_acked;
        logic [31:0] win_total;
        logic [31:0] pct;
        t_stats      s;
        case (op)
            OP_TICK:   ms_now = ms_now + 32'd1;
            OP_SEND:   n_sent = n_sent + 32'd1;
            OP_ACK: begin
                n_acked     = n_acked + 32'd1;
                tl_bytes    = tl_bytes + {24'd0, len};
                last_ack_ms = ms_now;
            end
            OP_ERROR:  n_errors = n_errors + 32'd1;
            OP_MISSED: n_missed = n_missed + {16'd0, miss};
            OP_UPDATE: begin
                span = ms_now - r_start;
                if (span > {16'd0, model_window}) begin
                    scaled  = (tl_bytes - tl_mark) * MS_PER_S;
                    tl_rate = scaled / span;
                    tl_mark = tl_bytes;
                    r_start = ms_now;
                end
                span = ms_now - q_start;
                if (span > {16'd0, model_window}) begin
                    // window counts are differences modulo 2^16
                    all_pkts  = n_sent + n_missed;
                    win_acked = {16'd0, n_acked[15:0] - q_mark_acked[15:0]};
                    win_total = {16'd0, all_pkts[15:0] - q_mark_total[15:0]};
                    w_acked   = (win_acked > WINDOW_ACK_MAX) ? 8'hFF : win_acked[7:0];
                    pct       = '0;
                    if (win_total != 32'd0) begin
                        pct = (win_acked * PCT_FULL) / win_total;
                        if (pct > PCT_FULL)
                            pct = PCT_FULL;
                    end
                    q_pct        = pct[6:0];
                    q_mark_acked = n_acked;
                    q_mark_total = all_pkts;
                    q_start      = ms_now;
                    windows_closed++;
                end
            end
            OP_CLEAR:  restart_link_stats();
            default:   ;
        endcase
        s.failsafe     = ((ms_now - last_ack_ms) >= {16'd0, model_failsafe});
        s.quality_pct  = q_pct;
        s.acked_window = w_acked;
        s.rate         = tl_rate;
        s.sent         = n_sent;
        s.acked        = n_acked;
        s.errors       = n_errors;
        s.missed       = n_missed;
        return s;
    endfunction

    // Offer one request; entered and left just after a falling edge
    task automatic push_request(t_row r);
        t_stats predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_op     = r.op;
        in_length = r.length;
        in_missed = r.missed;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        predicted = advance_link_stats(r.op, r.length, r.missed);
        pending_results.push_back(r.typed ? r.want : predicted);
        n_requests++;
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        if (idx == REG_FAILSAFE)
            model_failsafe = value;
        else
            model_window = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(int count);
        int         left;
        int         burst;
        int         pick;
        logic [2:0] op;
        left = count;
        while (left > 0) begin
            if ($urandom_range(9) < 7) begin
                // a stretch of traffic closed by an update
                burst = $urandom_range(12, 3);
                repeat (burst) begin
                    pick = $urandom_range(99);
                    if (pick < 38)
                        op = OP_TICK;
                    else if (pick < 60)
                        op = OP_SEND;
                    else if (pick < 80)
                        op = OP_ACK;
                    else if (pick < 86)
                        op = OP_ERROR;
                    else if (pick < 95)
                        op = OP_MISSED;
                    else if (pick < 98)
                        op = OP_UPDATE;
                    else
                        op = OP_CLEAR;
                    push_request(traffic_row(op, 8'($urandom),
                        ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3))));
                    left--;
                end
                push_request(traffic_row(OP_UPDATE, 8'($urandom), 16'($urandom)));
                left--;
            end else begin
                push_request(traffic_row(3'($urandom_range(7)), 8'($urandom), 16'($urandom)));
                left--;
            end
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic wait_drained();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            fail_count += pending_results.size();
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin : check_result
        t_stats seen;
        t_stats want;
        if (rst_n && o_out_valid && !out_stall) begin
            seen = stats_of(o_failsafe, o_link_quality_pct, o_acked_per_window,
                            o_telemetry_rate, o_sent_count, o_acked_count,
                            o_error_count, o_missed_total);
            n_results++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t: result with no request waiting, expected none, got %h",
                             $time, seen);
                end
            end else begin
                want = pending_results.pop_front();
                compare_field("failsafe", 32'(want.failsafe), 32'(seen.failsafe));
                compare_field("link_quality_pct", 32'(want.quality_pct),
                              32'(seen.quality_pct));
                compare_field("acked_per_window", 32'(want.acked_window),
                              32'(seen.acked_window));
                compare_field("telemetry_rate", want.rate, seen.rate);
                compare_field("sent_count", want.sent, seen.sent);
                compare_field("acked_count", want.acked, seen.acked);
                compare_field("error_count", want.errors, seen.errors);
                compare_field("missed_total", want.missed, seen.missed);
            end
        end
    end

    // Receiver: random stall, or one long hold-off while the sender keeps offering
    always @(negedge clk) begin
        if (hold_pending && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int phase;
        int row_idx;

        // Reset defaults: unused op, every counting op, field extremes, clear
        add_row(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1, stats_of(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(OP_SEND,   8'hFF, 16'hFFFF, 1'b1, stats_of(1, 0, 0, 0, 1, 0, 0, 0));
        add_row(OP_ACK,    8'hFF, 16'h0000, 1'b1, stats_of(0, 0, 0, 0, 1, 1, 0, 0));
        add_row(OP_ACK,    8'h00, 16'hFFFF, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 0, 0));
        add_row(OP_ERROR,  8'hFF, 16'hFFFF, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 1, 0));
        add_row(OP_MISSED, 8'hFF, 16'hFFFF, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 1, 32'hFFFF));
        add_row(OP_MISSED, 8'h00, 16'h0000, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 1, 32'hFFFF));
        add_row(OP_TICK,   8'hFF, 16'hFFFF, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 1, 32'hFFFF));
        add_row(OP_UPDATE, 8'hFF, 16'hFFFF, 1'b1, stats_of(0, 0, 0, 0, 1, 2, 1, 32'hFFFF));
        add_row(OP_CLEAR,  8'hFF, 16'hFFFF, 1'b1, stats_of(1, 0, 0, 0, 0, 0, 0, 0));
        // Window and period of 1: a window that closes, then one that saturates quality
        add_row(OP_SEND,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_SEND,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_SEND,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_ACK,    8'hFF, 16'hFFFF, 1'b0, '0);
        add_row(OP_ACK,    8'd10, 16'h0000, 1'b0, '0);
        add_row(OP_MISSED, 8'h00, 16'd1,    1'b0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_UPDATE, 8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_ACK,    8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_ACK,    8'd7,  16'h0000, 1'b0, '0);
        add_row(OP_SEND,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1'b0, '0);
        add_row(OP_UPDATE, 8'h00, 16'h0000, 1'b0, '0);

        model_failsafe = DEFAULT_PERIOD;
        model_window   = DEFAULT_PERIOD;
        ms_now         = '0;
        w_acked        = '0;
        restart_link_stats();

        rst_n = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (row_idx = 0; row_idx < DIRECTED_SPLIT; row_idx++)
            push_request(directed_rows[row_idx]);
        wait_drained();
        @(negedge clk);
        write_register(REG_FAILSAFE, 16'd1);
        write_register(REG_WINDOW, 16'd1);
        for (row_idx = DIRECTED_SPLIT; row_idx < directed_rows.size(); row_idx++)
            push_request(directed_rows[row_idx]);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = phase_send_idle[phase];
            recv_idle_pct = phase_recv_idle[phase];
            if (phase == HOLD_PHASE)
                hold_pending = 1'b1;
            @(negedge clk);
            write_register(REG_FAILSAFE, phase_failsafe[phase]);
            write_register(REG_WINDOW, phase_window[phase]);
            if (phase == BURST_PHASE) begin
                // overflow the per-window ack count
                repeat (2)
                    push_request(traffic_row(OP_SEND, 8'($urandom), 16'($urandom)));
                repeat (ACK_BURST)
                    push_request(traffic_row(OP_ACK, 8'($urandom), 16'($urandom)));
                repeat (4)
                    push_request(traffic_row(OP_TICK, 8'($urandom), 16'($urandom)));
                push_request(traffic_row(OP_UPDATE, 8'($urandom), 16'($urandom)));
            end
            run_random(phase_items[phase]);
            wait_drained();
        end

        $display("Sent %0d requests over %0d register settings, checked %0d results;",
                 n_requests, PHASES + 2, n_results);
        $display("%0d quality windows closed, receiver hold-off and both idling mixes exercised.",
                 windows_closed);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
